### rtl/core/msdt_pkg.sv
// ----------------------------------------------------------------------------
// Motor stop deadline timer package
// Shared types and codes for the deadline timer datapath and its top level.
// ----------------------------------------------------------------------------
package msdt_pkg;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_PULSE  = 3'd1,
        ACT_LEASE  = 3'd2,
        ACT_RENEW  = 3'd3,
        ACT_CANCEL = 3'd4
    } action_t;

    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_NORMAL   = 2'd1;
    localparam logic [1:0] EV_BACKSTOP = 2'd2;

    localparam logic [2:0] FAIL_NONE      = 3'd0;
    localparam logic [2:0] FAIL_NOT_READY = 3'd1;
    localparam logic [2:0] FAIL_DURATION  = 3'd2;
    localparam logic [2:0] FAIL_RANGE     = 3'd3;
    localparam logic [2:0] FAIL_STATE     = 3'd4;

    localparam logic CFG_TIMER_ENABLED = 1'b0;
    localparam logic CFG_MAX_LEASE_MS  = 1'b1;

    localparam logic [15:0] MAX_LEASE_RESET = 16'd100;
    localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        armed;
        logic        lease_mode;
        logic [31:0] tick_count;
        logic [31:0] normal_deadline;
        logic [31:0] hard_limit;
    } timer_state_t;

    // Packed so that accepted sits in the lowest bit.
    typedef struct packed {
        logic       is_armed;
        logic [2:0] failure;
        logic [1:0] stop_event;
        logic       accepted;
    } step_result_t;

endpackage

### rtl/core/msdt_step.sv
// ----------------------------------------------------------------------------
// Deadline timer step logic
// Works out the next timer state and the result for one registered request.
// ----------------------------------------------------------------------------
module msdt_step #(
    parameter int TICKS_PER_MS = 10
) (
    input  logic                  timer_enabled,
    input  logic [15:0]           max_lease_ms,
    input  msdt_pkg::timer_state_t state,
    input  msdt_pkg::action_t     action,
    input  logic [31:0]           duration_ms,
    input  logic [31:0]           guard_ms,
    output msdt_pkg::timer_state_t state_next,
    output msdt_pkg::step_result_t result
);

    localparam int TW = $clog2(TICKS_PER_MS + 1);
    localparam int MW = 32 + TW;

    logic [MW-1:0] dur_ticks;
    logic [MW-1:0] guard_ticks;
    logic [31:0]   lease_ticks;
    logic [31:0]   count_inc;
    logic [31:0]   renew_diff;
    logic          lease_ok;
    logic          too_long;

    assign dur_ticks   = MW'(duration_ms) * MW'(TICKS_PER_MS);
    assign guard_ticks = MW'(guard_ms) * MW'(TICKS_PER_MS);
    assign lease_ticks = dur_ticks[31:0] - 32'(TICKS_PER_MS);
    assign too_long    = (|dur_ticks[MW-1:32]) || (|guard_ticks[MW-1:32]);
    assign lease_ok    = (duration_ms >= 32'd2) && (duration_ms <= {16'd0, max_lease_ms});
    assign count_inc   = state.tick_count + 32'd1;
    assign renew_diff  = state.tick_count - state.normal_deadline;

    always_comb begin
        state_next        = state;
        result.accepted   = 1'b0;
        result.stop_event = msdt_pkg::EV_NONE;
        result.failure    = msdt_pkg::FAIL_NONE;
        unique case (action)
            msdt_pkg::ACT_TICK: begin
                if (state.armed) begin
                    if ((state.tick_count == state.hard_limit) ||
                        (state.lease_mode && (state.tick_count == msdt_pkg::COUNT_MAX))) begin
                        result.stop_event     = msdt_pkg::EV_BACKSTOP;
                        state_next.armed      = 1'b0;
                        state_next.tick_count = 32'd0;
                    end else if (count_inc == state.normal_deadline) begin
                        result.stop_event     = msdt_pkg::EV_NORMAL;
                        state_next.armed      = 1'b0;
                        state_next.tick_count = 32'd0;
                    end else begin
                        state_next.tick_count = count_inc;
                    end
                end
            end
            msdt_pkg::ACT_PULSE: begin
                state_next.armed      = 1'b0;
                state_next.tick_count = 32'd0;
                if (!timer_enabled) begin
                    result.failure = msdt_pkg::FAIL_NOT_READY;
                end else if ((duration_ms == 32'd0) || (guard_ms <= duration_ms)) begin
                    result.failure = msdt_pkg::FAIL_DURATION;
                end else if (too_long) begin
                    result.failure = msdt_pkg::FAIL_RANGE;
                end else begin
                    state_next.lease_mode      = 1'b0;
                    state_next.normal_deadline = dur_ticks[31:0];
                    state_next.hard_limit      = guard_ticks[31:0] - 32'd1;
                    state_next.armed           = 1'b1;
                    result.accepted            = 1'b1;
                end
            end
            msdt_pkg::ACT_LEASE: begin
                if (!timer_enabled) begin
                    result.failure = msdt_pkg::FAIL_NOT_READY;
                end else if (state.armed) begin
                    result.failure = msdt_pkg::FAIL_STATE;
                end else if (!lease_ok) begin
                    result.failure = msdt_pkg::FAIL_DURATION;
                end else begin
                    state_next.lease_mode      = 1'b1;
                    state_next.hard_limit      = msdt_pkg::COUNT_MAX;
                    state_next.normal_deadline = lease_ticks;
                    state_next.tick_count      = 32'd0;
                    state_next.armed           = 1'b1;
                    result.accepted            = 1'b1;
                end
            end
            msdt_pkg::ACT_RENEW: begin
                if (!timer_enabled) begin
                    result.failure = msdt_pkg::FAIL_NOT_READY;
                end else if (!state.armed) begin
                    result.failure = msdt_pkg::FAIL_STATE;
                end else if (!lease_ok) begin
                    result.failure = msdt_pkg::FAIL_DURATION;
                end else if (!renew_diff[31]) begin
                    result.stop_event     = msdt_pkg::EV_NORMAL;
                    state_next.armed      = 1'b0;
                    state_next.tick_count = 32'd0;
                end else begin
                    state_next.normal_deadline = state.tick_count + lease_ticks;
                    result.accepted            = 1'b1;
                end
            end
            msdt_pkg::ACT_CANCEL: begin
                state_next.armed      = 1'b0;
                state_next.tick_count = 32'd0;
                result.accepted       = 1'b1;
            end
            default: begin
            end
        endcase
        result.is_armed = state_next.armed;
    end

endmodule

### rtl/core/motor_stop_deadline_timer_top.sv
// ----------------------------------------------------------------------------
// Motor stop deadline timer
// Tick-driven deadline timer with pulse and lease runs for stopping a motor.
// ----------------------------------------------------------------------------
// Each request on the s_ channel is a tick (0.1 ms) or a command: arm pulse,
// arm lease, renew lease or cancel. Every request yields exactly one result
// on the m_ channel carrying accepted, stop_event, failure and is_armed.
// A request is captured into an input register, evaluated against the timer
// state combinationally and written into the output register together with the
// new state; the m_ channel is driven straight from the output register.
// Throughput is one request per clock while m_tready does not stall; the state
// update lets the next request see the effect of the previous one.
// When the receiver stalls, the output register holds its result and the
// input register takes one more request; after that s_tready drops until
// m_tready returns. Reset clears the timer (disarmed, counter zero, backstop
// limit all ones), sets timer_enabled to 0 and max_lease_ms to 100, and
// empties both stages. The user must write the configuration registers through
// cfg_wr_en only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module motor_stop_deadline_timer_top #(
    parameter int TICKS_PER_MS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // action[2:0], duration_ms[34:3], guard_ms[66:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // accepted[0], stop_event[2:1], failure[5:3], is_armed[6]
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic                   in_valid_reg;
    msdt_pkg::action_t      in_action_reg;
    logic [31:0]            in_duration_reg;
    logic [31:0]            in_backstop_reg;
    msdt_pkg::timer_state_t state_reg;
    msdt_pkg::timer_state_t state_next;
    msdt_pkg::step_result_t result_next;
    msdt_pkg::step_result_t out_data_reg;
    logic                   out_valid_reg;
    logic                   timer_enabled_reg;
    logic [15:0]            max_lease_ms_reg;
    logic                   out_free;
    logic                   advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

    msdt_step #(
        .TICKS_PER_MS(TICKS_PER_MS)
    ) u_step (
        .timer_enabled(timer_enabled_reg),
        .max_lease_ms (max_lease_ms_reg),
        .state        (state_reg),
        .action       (in_action_reg),
        .duration_ms  (in_duration_reg),
        .guard_ms     (in_backstop_reg),
        .state_next   (state_next),
        .result       (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_enabled_reg <= 1'b0;
            max_lease_ms_reg  <= msdt_pkg::MAX_LEASE_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_addr == msdt_pkg::CFG_TIMER_ENABLED) begin
                timer_enabled_reg <= cfg_wdata[0];
            end else begin
                max_lease_ms_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg   <= msdt_pkg::action_t'(s_tdata[2:0]);
            in_duration_reg <= s_tdata[34:3];
            in_backstop_reg <= s_tdata[66:35];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.armed           <= 1'b0;
            state_reg.lease_mode      <= 1'b0;
            state_reg.tick_count      <= 32'd0;
            state_reg.normal_deadline <= 32'd0;
            state_reg.hard_limit      <= msdt_pkg::COUNT_MAX;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result_next;
        end
    end

endmodule

### rtl/core/msdt_checker.sv
// ----------------------------------------------------------------------------
// Deadline timer port checker
// Watches the result channel of the deadline timer for inconsistent results.
// ----------------------------------------------------------------------------
module msdt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A stalled result must stay on the bus unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // Any stop event leaves the timer disarmed.
    a_stop_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2:1] != msdt_pkg::EV_NONE)) |-> !m_tdata[6])
        else $error("stop event with timer still armed");

    // A request is never both accepted and refused, nor accepted with a stop.
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |->
            ((m_tdata[5:3] == msdt_pkg::FAIL_NONE) && (m_tdata[2:1] == msdt_pkg::EV_NONE)))
        else $error("accepted request carries a failure or stop");

    // A refused request produces no stop event.
    a_fail_no_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[5:3] != msdt_pkg::FAIL_NONE)) |->
            (m_tdata[2:1] == msdt_pkg::EV_NONE))
        else $error("failure reported together with a stop event");

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind motor_stop_deadline_timer_top msdt_checker u_msdt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
